### hdl/ps2mct_pkg.sv
// Package with the screen geometry, button layout and cursor arithmetic shared by the tracker.
package ps2mct_pkg;

    localparam int SCREEN_WIDTH  = 800;
    localparam int SCREEN_HEIGHT = 600;
    localparam int BUTTON_COUNT  = 9;
    localparam int MARGIN        = 20;

    localparam int POS_W  = 10;
    localparam int SUM_W  = 12;
    localparam int MASK_W = 9;

    // Highest position an axis may take after clamping, and the lowest (the margin).
    localparam logic [POS_W-1:0] X_LIMIT = POS_W'(SCREEN_WIDTH - MARGIN);
    localparam logic [POS_W-1:0] Y_LIMIT = POS_W'(SCREEN_HEIGHT - MARGIN);
    localparam logic [POS_W-1:0] LOW_LIMIT = POS_W'(MARGIN);

    // Packet byte zero bit positions.
    localparam int HEAD_LEFT   = 0;
    localparam int HEAD_RIGHT  = 1;
    localparam int HEAD_X_SIGN = 4;
    localparam int HEAD_Y_SIGN = 5;
    localparam int HEAD_X_OVF  = 6;
    localparam int HEAD_Y_OVF  = 7;

    // Button rectangles: left edge, top edge, and the far edges.
    typedef logic [POS_W:0] t_coord;

    localparam t_coord RECT_X0 [MASK_W] = '{
        11'd100, 11'd250, 11'd400, 11'd550,
        11'd100, 11'd250, 11'd400, 11'd550,
        11'd100
    };
    localparam t_coord RECT_Y0 [MASK_W] = '{
        11'd100, 11'd100, 11'd100, 11'd100,
        11'd190, 11'd190, 11'd190, 11'd190,
        11'd420
    };
    localparam t_coord RECT_X1 [MASK_W] = '{
        11'd240, 11'd390, 11'd540, 11'd690,
        11'd240, 11'd390, 11'd540, 11'd690,
        11'd240
    };
    localparam t_coord RECT_Y1 [MASK_W] = '{
        11'd180, 11'd180, 11'd180, 11'd180,
        11'd230, 11'd230, 11'd230, 11'd230,
        11'd500
    };

    // Clamp a signed sum to the range from the margin up to the given limit.
    function automatic logic [POS_W-1:0] clamp_axis(
        input logic signed [SUM_W-1:0] v,
        input logic [POS_W-1:0]        limit
    );
        logic [POS_W-1:0] res;
        if (v <= $signed({{(SUM_W-POS_W){1'b0}}, LOW_LIMIT})) begin
            res = LOW_LIMIT;
        end else if (v >= $signed({{(SUM_W-POS_W){1'b0}}, limit})) begin
            res = limit;
        end else begin
            res = v[POS_W-1:0];
        end
        return res;
    endfunction

    // One bit for each button that strictly contains the point.
    function automatic logic [MASK_W-1:0] hit_test(
        input logic [POS_W-1:0] x,
        input logic [POS_W-1:0] y
    );
        logic [MASK_W-1:0] mask;
        t_coord            xe;
        t_coord            ye;
        mask = '0;
        xe   = {1'b0, x};
        ye   = {1'b0, y};
        for (int i = 0; i < MASK_W; i++) begin
            if (i < BUTTON_COUNT && xe > RECT_X0[i] && xe < RECT_X1[i] &&
                ye > RECT_Y0[i] && ye < RECT_Y1[i]) begin
                mask[i] = 1'b1;
            end
        end
        return mask;
    endfunction

endpackage

### hdl/ps2_mouse_cursor_tracker.sv
// Top level of the PS/2 mouse packet decoder and cursor tracker.
// A result appears in the output register in the cycle after the third byte of a packet
// is transferred in. Throughput: one byte per cycle, limited only by the single
// output register; bytes that do not complete a packet are never stalled.
// Reset (synchronous, active low) clears the byte count, the cursor position and the
// output valid flag; the two held header bytes are not reset.
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_mouse_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_cursor_x,
    output logic [POS_W-1:0]  o_cursor_y,
    output logic              o_left_pressed,
    output logic              o_right_pressed,
    output logic [MASK_W-1:0] o_hit_mask
);

    // Byte count of the packet being gathered: zero, one or two bytes held.
    logic [1:0]              r_byte_count;
    logic [1:0]              n_byte_count;
    logic [7:0]              r_head0;
    logic [7:0]              r_head1;
    logic [POS_W-1:0]        r_pos_x;
    logic [POS_W-1:0]        r_pos_y;
    logic [POS_W-1:0]        n_pos_x;
    logic [POS_W-1:0]        n_pos_y;

    logic                    r_out_valid;
    logic                    n_out_valid;
    logic [POS_W-1:0]        r_cursor_x;
    logic [POS_W-1:0]        r_cursor_y;
    logic                    r_left;
    logic                    r_right;
    logic [MASK_W-1:0]       r_hit_mask;

    logic                    last_byte;
    logic                    in_xfer;
    logic                    out_xfer;
    logic                    pkt_done;
    logic signed [SUM_W-1:0] dx;
    logic signed [SUM_W-1:0] dy;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic [MASK_W-1:0]       hits;

    // The third byte of a packet needs room in the output register; the first two
    // bytes only update the header and are always taken.
    assign last_byte  = r_byte_count[1];
    assign o_in_stall = last_byte && r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_xfer   = r_out_valid && !i_out_stall;
    assign pkt_done   = in_xfer && last_byte;

    // The movement fields are 9-bit two's complement, with the sign held in the header.
    // The position is extended to a signed sum so that a move past the low margin
    // clamps instead of wrapping around.
    always_comb begin
        dx    = $signed({{(SUM_W-8){r_head0[HEAD_X_SIGN]}}, r_head1});
        dy    = $signed({{(SUM_W-8){r_head0[HEAD_Y_SIGN]}}, i_mouse_byte});
        sum_x = $signed({{(SUM_W-POS_W){1'b0}}, r_pos_x}) + dx;
        sum_y = $signed({{(SUM_W-POS_W){1'b0}}, r_pos_y}) - dy;

        // An axis whose overflow bit is set keeps its old position.
        n_pos_x = r_head0[HEAD_X_OVF] ? r_pos_x : clamp_axis(sum_x, X_LIMIT);
        n_pos_y = r_head0[HEAD_Y_OVF] ? r_pos_y : clamp_axis(sum_y, Y_LIMIT);

        // Buttons are only tested while the left button is held.
        hits = r_head0[HEAD_LEFT] ? hit_test(n_pos_x, n_pos_y) : '0;
    end

    always_comb begin
        n_byte_count = r_byte_count;
        if (in_xfer) begin
            n_byte_count = last_byte ? 2'd0 : r_byte_count + 2'd1;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (pkt_done) begin
            n_out_valid = 1'b1;
        end else if (out_xfer) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= 2'd0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_byte_count <= n_byte_count;
            r_out_valid  <= n_out_valid;
            if (pkt_done) begin
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
            end
        end
    end

    // Header bytes and the result payload need no reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer && r_byte_count == 2'd0) begin
            r_head0 <= i_mouse_byte;
        end
        if (in_xfer && r_byte_count == 2'd1) begin
            r_head1 <= i_mouse_byte;
        end
        if (pkt_done) begin
            r_cursor_x <= n_pos_x;
            r_cursor_y <= n_pos_y;
            r_left     <= r_head0[HEAD_LEFT];
            r_right    <= r_head0[HEAD_RIGHT];
            r_hit_mask <= hits;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cursor_x      = r_cursor_x;
    assign o_cursor_y      = r_cursor_y;
    assign o_left_pressed  = r_left;
    assign o_right_pressed = r_right;
    assign o_hit_mask      = r_hit_mask;

endmodule

### hdl/ps2mct_checker.sv
// Port-level checker for the cursor tracker and the bind that attaches it.
module ps2mct_checker
    import ps2mct_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic [7:0]        i_mouse_byte,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [POS_W-1:0]  o_cursor_x,
    input logic [POS_W-1:0]  o_cursor_y,
    input logic              o_left_pressed,
    input logic              o_right_pressed,
    input logic [MASK_W-1:0] o_hit_mask
);

    // A stalled result stays offered with the same position, hit mask and left button.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_cursor_x) &&
            $stable(o_cursor_y) && $stable(o_hit_mask) && $stable(o_left_pressed))
        else $error("stalled result changed");

    // No result is offered in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Positions never pass the upper clamp limit.
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cursor_x <= X_LIMIT && o_cursor_y <= Y_LIMIT)
        else $error("cursor beyond clamp limit");

    // Hits need the left button, and the buttons do not overlap.
    a_hit_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_hit_mask != '0 |-> o_left_pressed && $onehot0(o_hit_mask))
        else $error("bad hit mask");

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_ps2mct_checker (.*);
